>>> sv/ibb_pkg.sv
// Shared constants for the integer-to-bignum-bytes block.
// No dependencies; imported by every module of the block.
package ibb_pkg;

    localparam int VALUE_BITS_DEF  = 128;
    localparam int IN_HALF_W       = 64;
    localparam int BYTE_W          = 8;
    localparam int COUNT_W         = 5;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;

endpackage

>>> sv/ibb_front.sv
// Front stage: input register, masking, sign detection, magnitude and byte count.
// Depends on ibb_pkg; feeds the queue ahead of ibb_back.
module ibb_front #(
    parameter int VALUE_BITS = ibb_pkg::VALUE_BITS_DEF,
    parameter int MAG_W      = ((VALUE_BITS + ibb_pkg::BYTE_W - 1) / ibb_pkg::BYTE_W)
                               * ibb_pkg::BYTE_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [ibb_pkg::IN_HALF_W-1:0]   i_value_high,
    input  logic [ibb_pkg::IN_HALF_W-1:0]   i_value_low,
    input  logic                            i_is_signed,
    output logic                            o_q_push,
    input  logic                            i_q_full,
    output logic [MAG_W-1:0]                o_mag,
    output logic [ibb_pkg::COUNT_W-1:0]     o_count,
    output logic                            o_neg
);
    import ibb_pkg::*;

    localparam int NB = MAG_W / BYTE_W;

    logic                      r_valid;
    logic                      n_valid;
    logic [MAG_W-1:0]          r_mag;
    logic [MAG_W-1:0]          n_mag;
    logic                      r_neg;
    logic [2*IN_HALF_W-1:0]    value_full;
    logic [VALUE_BITS-1:0]     value;
    logic [VALUE_BITS-1:0]     mag_core;
    logic                      neg;
    logic                      accept;
    logic [COUNT_W-1:0]        count;

    assign value_full = {i_value_high, i_value_low};
    assign value      = value_full[VALUE_BITS-1:0];
    assign neg        = i_is_signed & value[VALUE_BITS-1];
    assign mag_core   = neg ? (~value + VALUE_BITS'(1)) : value;

    always_comb begin
        n_mag = '0;
        n_mag[VALUE_BITS-1:0] = mag_core;
    end

    assign full     = r_valid & i_q_full;
    assign accept   = push & ~full;
    assign o_q_push = r_valid & ~i_q_full;

    always_comb begin
        priority if (accept) begin
            n_valid = 1'b1;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mag <= n_mag;
            r_neg <= neg;
        end
    end

    // highest nonzero byte sets the count; zero keeps one byte
    always_comb begin
        count = COUNT_W'(1);
        for (int k = 0; k < NB; k++) begin
            if (r_mag[k*BYTE_W +: BYTE_W] != '0) begin
                count = COUNT_W'(k + 1);
            end
        end
    end

    assign o_mag   = r_mag;
    assign o_count = count;
    assign o_neg   = r_neg;

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_q_full) |=> (r_valid && $stable(r_mag) && $stable(r_neg)))
        else $error("front entry changed while stalled");
`endif

endmodule

>>> sv/ibb_fifo.sv
// Short register queue between the front and back stages.
// Depends on ibb_pkg for the default depth.
module ibb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ibb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import ibb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count out of range");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == CNT_W'(DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

>>> sv/ibb_back.sv
// Back stage: walks the queued magnitude one byte per beat, most significant first.
// Depends on ibb_pkg; reads the head of ibb_fifo and drives the result register.
module ibb_back #(
    parameter int MAG_W = ibb_pkg::VALUE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_empty,
    input  logic [MAG_W-1:0]                i_mag,
    input  logic [ibb_pkg::COUNT_W-1:0]     i_count,
    input  logic                            i_neg,
    output logic                            o_q_pop,
    output logic                            empty,
    input  logic                            pop,
    output logic [ibb_pkg::BYTE_W-1:0]      o_data_byte,
    output logic [ibb_pkg::COUNT_W-1:0]     o_byte_count,
    output logic                            o_negative,
    output logic                            o_last
);
    import ibb_pkg::*;

    localparam int NB    = MAG_W / BYTE_W;
    localparam int IDX_W = (NB > 1) ? $clog2(NB) : 1;

    logic [BYTE_W-1:0]  mag_bytes [NB];
    logic [IDX_W-1:0]   r_pos;
    logic [IDX_W-1:0]   n_pos;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [BYTE_W-1:0]  r_byte;
    logic [COUNT_W-1:0] r_count;
    logic               r_neg;
    logic               r_last;
    logic               load;
    logic               head_last;
    logic [COUNT_W-1:0] sel_full;
    logic [IDX_W-1:0]   sel;
    logic [BYTE_W-1:0]  sel_byte;

    always_comb begin
        for (int k = 0; k < NB; k++) begin
            mag_bytes[k] = i_mag[k*BYTE_W +: BYTE_W];
        end
    end

    assign load      = ~i_q_empty & (~r_out_valid | pop);
    assign head_last = (COUNT_W'(r_pos) == i_count - COUNT_W'(1));
    assign sel_full  = i_count - COUNT_W'(1) - COUNT_W'(r_pos);
    assign sel       = sel_full[IDX_W-1:0];
    assign sel_byte  = i_neg ? (mag_bytes[sel] ^ BYTE_ONES) : mag_bytes[sel];
    assign o_q_pop   = load & head_last;

    always_comb begin
        n_pos = r_pos;
        if (load) begin
            n_pos = head_last ? '0 : r_pos + IDX_W'(1);
        end
    end

    always_comb begin
        priority if (load) begin
            n_out_valid = 1'b1;
        end else if (pop) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte  <= sel_byte;
            r_count <= i_count;
            r_neg   <= i_neg;
            r_last  <= head_last;
        end
    end

    assign empty        = ~r_out_valid;
    assign o_data_byte  = r_byte;
    assign o_byte_count = r_count;
    assign o_negative   = r_neg;
    assign o_last       = r_last;

`ifndef SYNTHESIS
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && pop && !r_last) |=> r_out_valid)
        else $error("gap inside one value");
    a_count_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && pop && !r_last) |=>
            (r_count == $past(r_count) && r_neg == $past(r_neg)))
        else $error("byte count or sign changed inside one value");
    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_empty |-> (r_pos == '0))
        else $error("byte position left set with no queued value");
`endif

endmodule

>>> sv/integer_to_bignum_bytes.sv
// Top level of the integer-to-bignum-bytes block.
// Depends on ibb_pkg, ibb_front, ibb_fifo and ibb_back.
//
// Input channel: an integer of VALUE_BITS bits (two 64-bit halves, bits above
// VALUE_BITS ignored) and a signed flag, taken when push is high and full low.
// Result channel: one beat per magnitude byte, most significant first, inverted
// when negative, with byte count, sign and last; taken when pop is high and
// empty low. Zero gives one 0x00 byte.
// The first byte of a value passes the front register, the queue and the back
// stage's result register. Throughput, set by the back stage's byte walk: one
// byte per cycle while pop is high and a value is queued (count 1 to MAG_W/8).
// The front stage and a two-entry queue keep accepting values while the back
// stage emits bytes, so new input stalls only when both are full.
// Reset clears all valid flags and the queue; nothing is pending afterwards.
// When the receiver holds pop low, the current byte stays on the outputs and
// the stall backs up through the queue to full.
module integer_to_bignum_bytes #(
    parameter int VALUE_BITS  = ibb_pkg::VALUE_BITS_DEF,
    parameter int QUEUE_DEPTH = ibb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [ibb_pkg::IN_HALF_W-1:0]   i_value_high,
    input  logic [ibb_pkg::IN_HALF_W-1:0]   i_value_low,
    input  logic                            i_is_signed,
    output logic                            empty,
    input  logic                            pop,
    output logic [ibb_pkg::BYTE_W-1:0]      o_data_byte,
    output logic [ibb_pkg::COUNT_W-1:0]     o_byte_count,
    output logic                            o_negative,
    output logic                            o_last
);
    import ibb_pkg::*;

    localparam int MAG_W   = ((VALUE_BITS + BYTE_W - 1) / BYTE_W) * BYTE_W;
    localparam int ENTRY_W = MAG_W + COUNT_W + 1;

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;
    logic [MAG_W-1:0]   f_mag;
    logic [COUNT_W-1:0] f_count;
    logic               f_neg;
    logic [ENTRY_W-1:0] q_wr;
    logic [ENTRY_W-1:0] q_rd;

    ibb_front #(
        .VALUE_BITS (VALUE_BITS),
        .MAG_W      (MAG_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_value_high (i_value_high),
        .i_value_low  (i_value_low),
        .i_is_signed  (i_is_signed),
        .o_q_push     (q_push),
        .i_q_full     (q_full),
        .o_mag        (f_mag),
        .o_count      (f_count),
        .o_neg        (f_neg)
    );

    assign q_wr = {f_neg, f_count, f_mag};

    ibb_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rd),
        .o_empty (q_empty)
    );

    ibb_back #(
        .MAG_W (MAG_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_mag        (q_rd[MAG_W-1:0]),
        .i_count      (q_rd[MAG_W +: COUNT_W]),
        .i_neg        (q_rd[ENTRY_W-1]),
        .o_q_pop      (q_pop),
        .empty        (empty),
        .pop          (pop),
        .o_data_byte  (o_data_byte),
        .o_byte_count (o_byte_count),
        .o_negative   (o_negative),
        .o_last       (o_last)
    );

endmodule

>>> tb/sv/integer_to_bignum_bytes_tb.sv
// Self-checking bench for integer_to_bignum_bytes: directed corner values, then random
// values of every byte length under four idling mixes. Depends on ibb_pkg and the RTL;
// a small board class predicts the magnitude bytes of each value and checks every beat.

typedef struct packed {
    logic [ibb_pkg::BYTE_W-1:0]  data;
    logic [ibb_pkg::COUNT_W-1:0] count;
    logic                        neg;
    logic                        last;
} t_byte_beat;

class bignum_byte_board;
    t_byte_beat awaited_bytes[$];
    int         mismatches;
    int         values_seen;
    int         negatives_seen;
    int         full_width_seen;
    int         beats_checked;

    function new();
        mismatches      = 0;
        values_seen     = 0;
        negatives_seen  = 0;
        full_width_seen = 0;
        beats_checked   = 0;
    endfunction

    function int outstanding();
        return awaited_bytes.size();
    endfunction

    function void note_value(logic [63:0] hi, logic [63:0] lo, logic sgn);
        logic [127:0] mag;
        logic         neg;
        int           nbytes;
        t_byte_beat   b;
        mag = {hi, lo};
        neg = sgn && mag[127];
        if (neg) begin
            mag = -mag;
        end
        nbytes = 1;
        for (int k = 1; k < 16; k++) begin
            if (mag[8*k +: 8] != 8'h00) begin
                nbytes = k + 1;
            end
        end
        for (int k = nbytes - 1; k >= 0; k--) begin
            b.data  = neg ? ~mag[8*k +: 8] : mag[8*k +: 8];
            b.count = nbytes[ibb_pkg::COUNT_W-1:0];
            b.neg   = neg;
            b.last  = (k == 0);
            awaited_bytes = {awaited_bytes, b};
        end
        values_seen++;
        if (neg) negatives_seen++;
        if (nbytes == 16) full_width_seen++;
    endfunction

    function void check_beat(t_byte_beat got, longint unsigned stamp);
        t_byte_beat want;
        if (awaited_bytes.size() == 0) begin
            $display("%0t: unexpected beat data=%h count=%0d neg=%b last=%b",
                     stamp, got.data, got.count, got.neg, got.last);
            mismatches++;
            return;
        end
        want = awaited_bytes.pop_front();
        beats_checked++;
        if (got.data != want.data) begin
            $display("%0t: data_byte expected %h actual %h", stamp, want.data, got.data);
            mismatches++;
        end
        if (got.count != want.count) begin
            $display("%0t: byte_count expected %0d actual %0d", stamp, want.count, got.count);
            mismatches++;
        end
        if (got.neg != want.neg) begin
            $display("%0t: negative expected %b actual %b", stamp, want.neg, got.neg);
            mismatches++;
        end
        if (got.last != want.last) begin
            $display("%0t: last expected %b actual %b", stamp, want.last, got.last);
            mismatches++;
        end
    endfunction
endclass

module integer_to_bignum_bytes_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int ITEMS_PER_MIX = 72;

    logic                          i_clk;
    logic                          i_rst_n = 1'b0;
    logic                          push = 1'b0;
    logic                          full;
    logic [ibb_pkg::IN_HALF_W-1:0] i_value_high = '0;
    logic [ibb_pkg::IN_HALF_W-1:0] i_value_low = '0;
    logic                          i_is_signed = 1'b0;
    logic                          empty;
    logic                          pop = 1'b0;
    logic [ibb_pkg::BYTE_W-1:0]    o_data_byte;
    logic [ibb_pkg::COUNT_W-1:0]   o_byte_count;
    logic                          o_negative;
    logic                          o_last;

    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               hold_request   = 0;
    int               quiet_cycles   = 0;
    bignum_byte_board board = new();

    integer_to_bignum_bytes dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_value_high (i_value_high),
        .i_value_low  (i_value_low),
        .i_is_signed  (i_is_signed),
        .empty        (empty),
        .pop          (pop),
        .o_data_byte  (o_data_byte),
        .o_byte_count (o_byte_count),
        .o_negative   (o_negative),
        .o_last       (o_last)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            board.note_value(i_value_high, i_value_low, i_is_signed);
        end
        if (i_rst_n && pop && !empty) begin
            board.check_beat(t_byte_beat'({o_data_byte, o_byte_count, o_negative, o_last}),
                             $time);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: a requested hold-off wins over random stalls
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                pop = 1'b0;
                hold_request = hold_request - 1;
            end else begin
                pop = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_value(input logic [63:0] hi, input logic [63:0] lo, input logic sgn);
        push         = 1'b1;
        i_value_high = hi;
        i_value_low  = lo;
        i_is_signed  = sgn;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic send_random_value();
        logic [127:0] v;
        logic         sgn;
        int           nbytes;
        v   = {$urandom, $urandom, $urandom, $urandom};
        sgn = 1'($urandom_range(1));
        if ($urandom_range(9) != 0) begin
            nbytes = $urandom_range(1, 16);
            if (nbytes < 16) begin
                v = v & ((128'd1 << (8 * nbytes)) - 128'd1);
            end
            if (sgn && $urandom_range(1)) begin
                v = -v;
            end
        end
        send_value(v[127:64], v[63:0], sgn);
    endtask

    task automatic drain_results();
        push = 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_value(64'h0, 64'h0, 1'b0);
        send_value(64'h0, 64'h0, 1'b1);
        send_value(64'h0, 64'h1, 1'b0);
        send_value(64'h0, 64'hFF, 1'b0);
        send_value(64'h0, 64'h100, 1'b0);
        send_value(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_value(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_value(64'h1, 64'h0, 1'b0);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_value(64'h8000_0000_0000_0000, 64'h0, 1'b1);
        send_value(64'h8000_0000_0000_0000, 64'h0, 1'b0);
        send_value(64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF80, 1'b1);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF7F, 1'b1);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF00, 1'b1);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0);
        send_value(64'h8000_0000_0000_0000, 64'h1, 1'b1);
        send_value(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        send_value(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1);
        send_value(64'h0, 64'h8000_0000_0000_0000, 1'b1);

        for (int mix = 0; mix < 4; mix++) begin
            case (mix)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            repeat (ITEMS_PER_MIX) send_random_value();
            if (mix == 0) begin
                // hold the receiver off while values keep coming, then let it all drain
                push = 1'b0;
                @(posedge i_clk);
                hold_request = HOLD_CYCLES;
                @(negedge i_clk);
                repeat (24) send_random_value();
                drain_results();
            end
        end

        drain_results();
        repeat (16) @(posedge i_clk);

        $display("covered %0d values (%0d negative, %0d at full 16-byte width), %0d byte beats",
                 board.values_seen, board.negatives_seen, board.full_width_seen,
                 board.beats_checked);
        $display("under four idling mixes, a %0d-cycle receiver hold-off and full drains",
                 HOLD_CYCLES);
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
